[design/rds_pkg.sv]
// ----------------------------------------------------------------------------
// rds_pkg
// Types, constants and sequencer states of the record density sorter.
// ----------------------------------------------------------------------------
package rds_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W       = 5;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] volume;
        logic        final_record;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] load_index;
        logic [31:0]      mass_out;
        logic [31:0]      volume_out;
        logic [31:0]      density_out;
        logic             overflowed;
        logic             end_of_batch;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [31:0]      mass;
        logic [31:0]      volume;
        logic [31:0]      density;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_SORT_SETUP,
        S_PASS_START,
        S_PASS_FIRST,
        S_PASS_RUN,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

[design/record_density_sorter.sv]
// ----------------------------------------------------------------------------
// record_density_sorter
// Loads mass/volume records, computes Q16.16 density, bubble-sorts the batch
// by density in one record memory and emits the records in ascending order.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  s_      | in        | in_item_t   | s_valid / s_ready
//  m_      | out       | out_item_t  | m_valid / m_ready
//
//  A load accepts the record, runs 32 restoring divider steps and stores it;
//  a saturating quotient skips the divider. Sort passes run over the record
//  memory, whose single read and write port move one record per cycle, and
//  the emit sequence reads and then loads each result. Reset is synchronous
//  and clears the count and the flag. A stalled m_ready holds the result
//  register and pauses the emit sequence; loading of the next batch starts
//  while the last result is still waiting.
module record_density_sorter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rds_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rds_pkg::out_item_t  m_data
);
    import rds_pkg::*;

    state_t state_reg, state_next;

    rec_t mem [MAX_RECORDS];
    rec_t rd_reg;
    rec_t held_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    rec_t              mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic [31:0]          mass_reg;
    logic [31:0]          vol_reg;
    logic                 final_reg;
    logic                 sat_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          num_reg;
    logic [31:0]          quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [ADDR_W-1:0]    k_reg;
    logic [ADDR_W-1:0]    end_reg;
    logic [ADDR_W-1:0]    e_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic        s_fire;
    logic        has_room;
    logic        in_sat;
    logic [32:0] rem_shift;
    logic        rem_ge;
    logic [31:0] rem_new;
    logic        swap;
    logic        emit_last;
    logic        out_free;

    assign s_fire   = s_valid && s_ready;
    assign has_room = count_reg < CNT_W'(MAX_RECORDS);
    // The quotient exceeds 32 bits exactly when mass[31:16] >= volume; this
    // also covers a zero volume.
    assign in_sat   = {16'b0, s_data.mass[31:16]} >= s_data.volume;

    assign rem_shift = {rem_reg, num_reg[31]};
    assign rem_ge    = rem_shift >= {1'b0, vol_reg};
    assign rem_new   = rem_ge ? 32'(rem_shift - {1'b0, vol_reg}) : rem_shift[31:0];

    // Only a strictly greater density moves the carried record upward.
    assign swap      = held_reg.density > rd_reg.density;
    assign emit_last = e_reg == ADDR_W'(count_reg - 1'b1);
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (has_room) begin
                        state_next = in_sat ? S_STORE : S_DIV;
                    end else if (s_data.final_record) begin
                        state_next = S_SORT_SETUP;
                    end
                end
            end
            S_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                state_next = final_reg ? S_SORT_SETUP : S_IDLE;
            end
            S_SORT_SETUP: begin
                if (count_reg == '0) begin
                    state_next = S_IDLE;
                end else if (count_reg == CNT_W'(1)) begin
                    state_next = S_EMIT_RD;
                end else begin
                    state_next = S_PASS_START;
                end
            end
            S_PASS_START: state_next = S_PASS_FIRST;
            S_PASS_FIRST: state_next = S_PASS_RUN;
            S_PASS_RUN: begin
                if (k_reg == end_reg) begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END: begin
                state_next = (end_reg == ADDR_W'(1)) ? S_EMIT_RD : S_PASS_START;
            end
            S_EMIT_RD: begin
                if (out_free) begin
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                state_next = emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = state_reg == S_IDLE;
        mem_we    = 1'b0;
        mem_waddr = k_reg - 1'b1;
        mem_wdata = held_reg;
        mem_re    = 1'b0;
        mem_raddr = k_reg + 1'b1;
        unique case (state_reg)
            S_STORE: begin
                mem_we            = 1'b1;
                mem_waddr         = count_reg[ADDR_W-1:0];
                mem_wdata.index   = IDX_W'(count_reg);
                mem_wdata.mass    = mass_reg;
                mem_wdata.volume  = vol_reg;
                mem_wdata.density = sat_reg ? 32'hFFFF_FFFF : quo_reg;
            end
            S_PASS_START: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            S_PASS_FIRST: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(1);
            end
            S_PASS_RUN: begin
                mem_we    = 1'b1;
                mem_wdata = swap ? rd_reg : held_reg;
                mem_re    = k_reg != end_reg;
            end
            S_PASS_END: begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
            end
            S_EMIT_RD: begin
                mem_re    = out_free;
                mem_raddr = e_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && !has_room) begin
                        ovf_reg <= 1'b1;
                    end
                end
                S_STORE: count_reg <= count_reg + 1'b1;
                S_EMIT_LD: begin
                    m_valid_reg <= 1'b1;
                    if (emit_last) begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                mass_reg    <= s_data.mass;
                vol_reg     <= s_data.volume;
                final_reg   <= s_data.final_record;
                sat_reg     <= in_sat;
                rem_reg     <= {16'b0, s_data.mass[31:16]};
                num_reg     <= {s_data.mass[15:0], 16'b0};
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            S_DIV: begin
                rem_reg     <= rem_new;
                num_reg     <= {num_reg[30:0], 1'b0};
                quo_reg     <= {quo_reg[30:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            S_SORT_SETUP: begin
                end_reg <= ADDR_W'(count_reg - 1'b1);
                e_reg   <= '0;
            end
            S_PASS_FIRST: begin
                held_reg <= rd_reg;
                k_reg    <= ADDR_W'(1);
            end
            S_PASS_RUN: begin
                if (!swap) begin
                    held_reg <= rd_reg;
                end
                if (k_reg != end_reg) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_PASS_END: begin
                end_reg <= end_reg - 1'b1;
            end
            S_EMIT_LD: begin
                m_data_reg.load_index   <= rd_reg.index;
                m_data_reg.mass_out     <= rd_reg.mass;
                m_data_reg.volume_out   <= rd_reg.volume;
                m_data_reg.density_out  <= rd_reg.density;
                m_data_reg.overflowed   <= ovf_reg;
                m_data_reg.end_of_batch <= emit_last;
                e_reg                   <= e_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record density sorter. Batches of mass/volume
// records are sent with random gaps. A tracker class mirrors the load, the
// saturating Q16.16 density and the stable bubble sort. It checks every
// emitted record against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
    import rds_pkg::*;

    // Stable ascending sort of each batch; holds the records still to be emitted.
    class density_batch_tracker;
        rec_t        loaded_q[$];
        bit          dropped;
        out_item_t   sorted_q[$];
        int unsigned mismatch_count;

        function new();
            dropped        = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction

        function bit [31:0] q16_density(bit [31:0] mass, bit [31:0] volume);
            bit [63:0] quotient;
            if (volume == 32'd0) begin
                return 32'hFFFF_FFFF;
            end
            quotient = {16'd0, mass, 16'd0} / {32'd0, volume};
            if (quotient[63:32] != 32'd0) begin
                return 32'hFFFF_FFFF;
            end
            return quotient[31:0];
        endfunction

        function void load_record(in_item_t item);
            rec_t      rec;
            rec_t      held;
            out_item_t res;
            int        count;
            if (loaded_q.size() < MAX_RECORDS) begin
                rec.index   = IDX_W'(loaded_q.size());
                rec.mass    = item.mass;
                rec.volume  = item.volume;
                rec.density = q16_density(item.mass, item.volume);
                loaded_q.push_back(rec);
            end else begin
                dropped = 1'b1;
            end
            if (!item.final_record) begin
                return;
            end
            count = loaded_q.size();
            // Only a strictly greater density moves toward the end, so ties keep load order.
            for (int pass = 0; pass < count; pass++) begin
                for (int k = 0; k + 1 + pass < count; k++) begin
                    if (loaded_q[k].density > loaded_q[k + 1].density) begin
                        held            = loaded_q[k];
                        loaded_q[k]     = loaded_q[k + 1];
                        loaded_q[k + 1] = held;
                    end
                end
            end
            for (int k = 0; k < count; k++) begin
                res.load_index   = loaded_q[k].index;
                res.mass_out     = loaded_q[k].mass;
                res.volume_out   = loaded_q[k].volume;
                res.density_out  = loaded_q[k].density;
                res.overflowed   = dropped;
                res.end_of_batch = (k == count - 1);
                sorted_q.push_back(res);
            end
            loaded_q.delete();
            dropped = 1'b0;
        endfunction

        function void compare_field(string field, bit [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: %s mismatch, expected %h, got %h", $realtime, field,
                             want, seen);
                end
            end
        endfunction

        function void check_emitted(out_item_t seen);
            out_item_t want;
            if (sorted_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result transaction %h", $realtime, seen);
                end
                return;
            end
            want = sorted_q.pop_front();
            compare_field("load_index", 32'(want.load_index), 32'(seen.load_index));
            compare_field("mass_out", want.mass_out, seen.mass_out);
            compare_field("volume_out", want.volume_out, seen.volume_out);
            compare_field("density_out", want.density_out, seen.density_out);
            compare_field("overflowed", 32'(want.overflowed), 32'(seen.overflowed));
            compare_field("end_of_batch", 32'(want.end_of_batch),
                          32'(seen.end_of_batch));
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    density_batch_tracker tracker = new();
    int        records_sent = 0;
    bit        rx_burst     = 1'b0;
    bit [31:0] prev_mass    = 32'd0;
    bit [31:0] prev_volume  = 32'd1;

    record_density_sorter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic in_item_t make_item(bit [31:0] mass, bit [31:0] volume, bit fin);
        in_item_t item;
        item.mass         = mass;
        item.volume       = volume;
        item.final_record = fin;
        return item;
    endfunction

    function automatic bit [31:0] corner_value();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'h0001_0000;
            3: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mix of plain random, narrow values, zero volume, repeated records for
    // ties, tiny volumes that saturate, and corner values.
    function automatic in_item_t random_record();
        in_item_t item;
        item.final_record = 1'b0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                item.mass   = $urandom;
                item.volume = $urandom;
            end
            4, 5: begin
                item.mass   = $urandom_range(0, 32'h0003_FFFF);
                item.volume = $urandom_range(0, 32'h0003_FFFF);
            end
            6: begin
                item.mass   = $urandom;
                item.volume = 32'd0;
            end
            7: begin
                item.mass   = prev_mass;
                item.volume = prev_volume;
            end
            8: begin
                item.mass   = $urandom;
                item.volume = $urandom_range(0, 255);
            end
            default: begin
                item.mass   = corner_value();
                item.volume = corner_value();
            end
        endcase
        prev_mass   = item.mass;
        prev_volume = item.volume;
        return item;
    endfunction

    task automatic send_record(in_item_t item, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.load_record(item);
        records_sent++;
    endtask

    task automatic send_batch(int count, bit burst);
        in_item_t item;
        for (int i = 0; i < count; i++) begin
            item              = random_record();
            item.final_record = (i == count - 1);
            send_record(item, burst);
        end
    endtask

    initial begin : stimulus
        int pick;
        int count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A batch of one record whose density saturates on zero volume.
        send_record(make_item(32'd0, 32'd0, 1'b1), 1'b0);

        // Extremes, the saturation edge and ties in one batch.
        send_record(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 1'b0);
        send_record(make_item(32'hFFFF_FFFF, 32'd1, 1'b0), 1'b0);
        send_record(make_item(32'd0, 32'hFFFF_FFFF, 1'b0), 1'b1);
        send_record(make_item(32'd1, 32'hFFFF_FFFF, 1'b0), 1'b0);
        send_record(make_item(32'h0001_0000, 32'h0001_0000, 1'b0), 1'b1);
        send_record(make_item(32'h0001_0000, 32'd0, 1'b0), 1'b0);
        send_record(make_item(32'h8000_0000, 32'h0000_8000, 1'b0), 1'b0);
        send_record(make_item(32'h0000_FFFF, 32'd1, 1'b0), 1'b0);
        send_record(make_item(32'h0001_0000, 32'd1, 1'b0), 1'b0);
        send_record(make_item(32'h0000_FFFF, 32'h0001_0000, 1'b1), 1'b0);

        // Strictly descending densities force a swap on every compare.
        for (int k = 0; k < 5; k++) begin
            send_record(make_item((5 - k) << 12, 32'h0001_0000, k == 4), 1'b1);
        end

        // Identical records must come out in load order.
        send_record(make_item(32'h0003_0000, 32'h0002_0000, 1'b0), 1'b0);
        send_record(make_item(32'h0003_0000, 32'h0002_0000, 1'b1), 1'b0);

        while (records_sent < 450) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                count = $urandom_range(1, 8);
            end else if (pick < 17) begin
                count = $urandom_range(9, 31);
            end else if (pick < 19) begin
                count = MAX_RECORDS;
            end else begin
                // The store fills up, so the final record is itself dropped.
                count = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
            end
            send_batch(count, $urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (tracker.mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            tracker.check_emitted(m_data);
            if ($urandom_range(0, 39) == 0) begin
                rx_burst = !rx_burst;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
